[hw/rtl/mch_pkg.sv]
// ----------------------------------------------------------------------------
// mch_pkg: shared types and constants of the monotone chain hull block
// Point and result payloads, control groups of the cells and sizing constants.
// ----------------------------------------------------------------------------
package mch_pkg;

  localparam int MAX_POINTS  = 32;
  localparam int MAX_RESULTS = 64;
  localparam int ECHO_COUNT  = 3;
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS);
  localparam int DIFF_W      = 33;
  localparam int PROD_W      = 2 * DIFF_W;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pt_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last_point;
  } item_t;

  typedef struct packed {
    logic signed [31:0] hull_x;
    logic signed [31:0] hull_y;
    logic               hull_last;
    logic               no_hull;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } sort_ctl_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_ctl_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } turn_t;

endpackage

[hw/rtl/mch_sort_cell.sv]
// ----------------------------------------------------------------------------
// mch_sort_cell: one cell of the systolic insertion sorter
// Keeps the smaller of its point and the arriving one and hands the larger on;
// in readout mode it takes the point of its right-hand neighbour.
// ----------------------------------------------------------------------------
module mch_sort_cell (
  input  logic              clk,
  input  logic              rst,
  input  mch_pkg::sort_ctl_t ctl,
  input  mch_pkg::pt_t      in_pt,
  input  logic              in_v,
  input  mch_pkg::pt_t      nb_pt,
  input  logic              nb_v,
  output mch_pkg::pt_t      out_pt,
  output logic              out_v,
  output mch_pkg::pt_t      held_pt,
  output logic              held_v
);

  logic in_less;

  // Order by x, then by y.
  assign in_less = (in_pt.x < held_pt.x) || ((in_pt.x == held_pt.x) && (in_pt.y < held_pt.y));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      held_v <= 1'b0;
      out_v  <= 1'b0;
    end else if (ctl.shift) begin
      held_pt <= nb_pt;
      held_v  <= nb_v;
      out_v   <= 1'b0;
    end else if (in_v) begin
      if (!held_v) begin
        held_pt <= in_pt;
        held_v  <= 1'b1;
        out_v   <= 1'b0;
      end else if (in_less) begin
        held_pt <= in_pt;
        out_pt  <= held_pt;
        out_v   <= 1'b1;
      end else begin
        out_pt <= in_pt;
        out_v  <= 1'b1;
      end
    end else begin
      out_v <= 1'b0;
    end
  end

endmodule

[hw/rtl/mch_stack.sv]
// ----------------------------------------------------------------------------
// mch_stack: point stack built as a shifting row of cells
// The top two entries sit in the first two cells; push and pop shift the row.
// ----------------------------------------------------------------------------
module mch_stack (
  input  logic                      clk,
  input  logic                      rst,
  input  mch_pkg::stk_ctl_t         ctl,
  input  mch_pkg::pt_t              din,
  output mch_pkg::pt_t              top,
  output mch_pkg::pt_t              second,
  output logic [mch_pkg::CNT_W-1:0] count
);

  mch_pkg::pt_t cells [mch_pkg::MAX_POINTS];

  assign top    = cells[0];
  assign second = cells[1];

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + 1'b1;
    end else if (ctl.pop) begin
      count <= count - 1'b1;
    end
  end

  for (genvar i = 0; i < mch_pkg::MAX_POINTS; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ctl.push) begin
        cells[i] <= (i == 0) ? din : cells[(i == 0) ? 0 : i - 1];
      end else if (ctl.pop) begin
        if (i < mch_pkg::MAX_POINTS - 1) begin
          cells[i] <= cells[(i < mch_pkg::MAX_POINTS - 1) ? i + 1 : i];
        end
      end
    end
  end

endmodule

[hw/rtl/mch_cross.sv]
// ----------------------------------------------------------------------------
// mch_cross: three-stage exact orientation test
// Sign of (q.y-p.y)*(r.x-p.x) - (q.x-p.x)*(r.y-p.y): differences, products, sign.
// ----------------------------------------------------------------------------
module mch_cross (
  input  logic           clk,
  input  mch_pkg::pt_t   p,
  input  mch_pkg::pt_t   q,
  input  mch_pkg::pt_t   r,
  output mch_pkg::turn_t turn
);

  logic signed [mch_pkg::DIFF_W-1:0]   d1, d2, d3, d4;
  logic signed [mch_pkg::PROD_W-1:0]   pa, pb;
  logic signed [mch_pkg::PROD_W:0]     diff;

  assign diff = {pa[mch_pkg::PROD_W-1], pa} - {pb[mch_pkg::PROD_W-1], pb};

  always_ff @(posedge clk) begin
    d1 <= {q.y[31], q.y} - {p.y[31], p.y};
    d2 <= {r.x[31], r.x} - {p.x[31], p.x};
    d3 <= {q.x[31], q.x} - {p.x[31], p.x};
    d4 <= {r.y[31], r.y} - {p.y[31], p.y};
    pa <= d1 * d2;
    pb <= d3 * d4;
    turn.neg  <= diff[mch_pkg::PROD_W];
    turn.zero <= (diff == '0);
  end

endmodule

[hw/rtl/monotone_chain_convex_hull.sv]
// ----------------------------------------------------------------------------
// monotone_chain_convex_hull: convex hull of an integer point path
// Points are taken one per cycle while loading (busy low). After the last point a
// short path passes through a decide state, the no-hull or echo states and a clear.
// A hull takes a decide state, a drain of the sorter row, a fetch per point (an
// extra one for the skipped start point of a closed path), an orientation test
// per fetch or pop, the reversal of the first chain, then the emission of the
// vertices and a clear.
// Throughput: one path at a time; results leave one per cycle and cannot stall.
// Reset (synchronous, rst high) empties the store and clears clockwise_order.
// ----------------------------------------------------------------------------
module monotone_chain_convex_hull (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mch_pkg::item_t    item,
  output logic              result_valid,
  output mch_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic              cfg_data
);

  // Controller states.
  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_NOHULL = 4'd2;
  localparam logic [3:0] S_ECHO   = 4'd3;
  localparam logic [3:0] S_DRAIN  = 4'd4;
  localparam logic [3:0] S_FETCH  = 4'd5;
  localparam logic [3:0] S_TEST   = 4'd6;
  localparam logic [3:0] S_WAIT   = 4'd7;
  localparam logic [3:0] S_EVAL   = 4'd8;
  localparam logic [3:0] S_REV0   = 4'd9;
  localparam logic [3:0] S_REV    = 4'd10;
  localparam logic [3:0] S_EMITR  = 4'd11;
  localparam logic [3:0] S_EMITS  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]               state, state_next;
  logic                     clockwise_order;
  logic [mch_pkg::CNT_W-1:0] point_count, point_count_next;
  logic                     dropped, dropped_next;
  logic                     closed, closed_next;
  logic                     skip, skip_next;
  logic [mch_pkg::CNT_W-1:0] remain, remain_next;
  logic [mch_pkg::CNT_W-1:0] drain_cnt, drain_cnt_next;
  logic                     wait_cnt, wait_cnt_next;
  logic [1:0]               echo_idx, echo_idx_next;
  logic [mch_pkg::RES_W-1:0] res_cnt, res_cnt_next;
  mch_pkg::pt_t             first_pt, last_pt, cur, cur_next;
  mch_pkg::pt_t             echo [mch_pkg::ECHO_COUNT];
  mch_pkg::result_t         result_next;
  logic                     result_valid_next;

  logic                     accept, store;
  mch_pkg::pt_t             in_pt;

  // Sorter row.
  mch_pkg::sort_ctl_t       sctl;
  mch_pkg::pt_t             sc_out  [mch_pkg::MAX_POINTS];
  logic                     sc_ov   [mch_pkg::MAX_POINTS];
  mch_pkg::pt_t             sc_held [mch_pkg::MAX_POINTS];
  logic                     sc_hv   [mch_pkg::MAX_POINTS];

  // Chain stacks and the reversal stack.
  mch_pkg::stk_ctl_t        uctl, lctl, rctl;
  mch_pkg::pt_t             u_top, u_sec, l_top, l_sec, r_top, r_sec, f_top, s_top;
  logic [mch_pkg::CNT_W-1:0] u_cnt, l_cnt, r_cnt, f_cnt, s_cnt;
  mch_pkg::turn_t           t_up, t_lo;
  logic                     pop_u, pop_l, cap_last;

  assign busy   = (state != S_LOAD);
  assign accept = start && !busy;
  assign store  = accept && (point_count < mch_pkg::CNT_W'(mch_pkg::MAX_POINTS));
  assign in_pt  = '{x: item.point_x, y: item.point_y};

  // The chain emitted bottom-up first is the upper one when clockwise.
  assign f_top = clockwise_order ? u_top : l_top;
  assign s_top = clockwise_order ? l_top : u_top;
  assign f_cnt = clockwise_order ? u_cnt : l_cnt;
  assign s_cnt = clockwise_order ? l_cnt : u_cnt;

  assign pop_u    = (u_cnt > mch_pkg::CNT_W'(1)) && (t_up.neg || t_up.zero);
  assign pop_l    = (l_cnt > mch_pkg::CNT_W'(1)) && !t_lo.neg;
  assign cap_last = (res_cnt == mch_pkg::RES_W'(mch_pkg::MAX_RESULTS - 1));

  // Each cell keeps the smaller point and passes the larger to the right, so
  // after the last insertion has rippled through, the row is sorted from cell 0.
  for (genvar i = 0; i < mch_pkg::MAX_POINTS; i++) begin : g_sort
    mch_pkg::pt_t nb_pt, left_pt;
    logic         nb_v, left_v;

    if (i == 0) begin : g_head
      assign left_pt = in_pt;
      assign left_v  = store;
    end else begin : g_body
      assign left_pt = sc_out[i-1];
      assign left_v  = sc_ov[i-1];
    end

    if (i == mch_pkg::MAX_POINTS - 1) begin : g_tail
      assign nb_pt = '0;
      assign nb_v  = 1'b0;
    end else begin : g_mid
      assign nb_pt = sc_held[i+1];
      assign nb_v  = sc_hv[i+1];
    end

    mch_sort_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (sctl),
      .in_pt   (left_pt),
      .in_v    (left_v),
      .nb_pt   (nb_pt),
      .nb_v    (nb_v),
      .out_pt  (sc_out[i]),
      .out_v   (sc_ov[i]),
      .held_pt (sc_held[i]),
      .held_v  (sc_hv[i])
    );
  end

  mch_stack u_upper (
    .clk (clk), .rst (rst), .ctl (uctl), .din (cur),
    .top (u_top), .second (u_sec), .count (u_cnt)
  );

  mch_stack u_lower (
    .clk (clk), .rst (rst), .ctl (lctl), .din (cur),
    .top (l_top), .second (l_sec), .count (l_cnt)
  );

  mch_stack u_rev (
    .clk (clk), .rst (rst), .ctl (rctl), .din (f_top),
    .top (r_top), .second (r_sec), .count (r_cnt)
  );

  // Both chains are tested against the current point in parallel.
  mch_cross u_cross_up (.clk (clk), .p (u_sec), .q (u_top), .r (cur), .turn (t_up));
  mch_cross u_cross_lo (.clk (clk), .p (l_sec), .q (l_top), .r (cur), .turn (t_lo));

  always_comb begin
    state_next        = state;
    point_count_next  = point_count;
    dropped_next      = dropped;
    closed_next       = closed;
    skip_next         = skip;
    remain_next       = remain;
    drain_cnt_next    = drain_cnt;
    wait_cnt_next     = wait_cnt;
    echo_idx_next     = echo_idx;
    res_cnt_next      = res_cnt;
    cur_next          = cur;
    sctl              = '0;
    uctl              = '0;
    lctl              = '0;
    rctl              = '0;
    result_valid_next = 1'b0;
    result_next       = '0;
    result_next.overflow = dropped;

    case (state)
      S_LOAD: begin
        if (accept) begin
          if (store) begin
            point_count_next = point_count + 1'b1;
          end else begin
            dropped_next = 1'b1;
          end
          if (item.last_point) begin
            state_next = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        res_cnt_next = '0;
        echo_idx_next = '0;
        if (point_count < mch_pkg::CNT_W'(mch_pkg::ECHO_COUNT)) begin
          state_next = S_NOHULL;
        end else if (point_count == mch_pkg::CNT_W'(mch_pkg::ECHO_COUNT)) begin
          state_next = S_ECHO;
        end else begin
          // A closed path loses its repeated end point; one copy of the start
          // point is skipped when the sorted points are read out.
          closed_next    = (first_pt == last_pt);
          skip_next      = (first_pt == last_pt);
          remain_next    = point_count - mch_pkg::CNT_W'(first_pt == last_pt);
          drain_cnt_next = '0;
          state_next     = S_DRAIN;
        end
      end
      S_NOHULL: begin
        result_valid_next     = 1'b1;
        result_next.hull_last = 1'b1;
        result_next.no_hull   = 1'b1;
        state_next            = S_DONE;
      end
      S_ECHO: begin
        result_valid_next     = 1'b1;
        result_next.hull_x    = echo[echo_idx].x;
        result_next.hull_y    = echo[echo_idx].y;
        result_next.hull_last = (echo_idx == 2'(mch_pkg::ECHO_COUNT - 1));
        echo_idx_next         = echo_idx + 1'b1;
        if (result_next.hull_last) begin
          state_next = S_DONE;
        end
      end
      S_DRAIN: begin
        drain_cnt_next = drain_cnt + 1'b1;
        if (drain_cnt == mch_pkg::CNT_W'(mch_pkg::MAX_POINTS - 1)) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        sctl.shift = 1'b1;
        if (skip && (sc_held[0] == first_pt)) begin
          skip_next = 1'b0;
        end else begin
          cur_next   = sc_held[0];
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        wait_cnt_next = 1'b0;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        wait_cnt_next = 1'b1;
        if (wait_cnt) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (pop_u || pop_l) begin
          uctl.pop   = pop_u;
          lctl.pop   = pop_l;
          state_next = S_TEST;
        end else begin
          uctl.push   = 1'b1;
          lctl.push   = 1'b1;
          remain_next = remain - 1'b1;
          state_next  = (remain == mch_pkg::CNT_W'(1)) ? S_REV0 : S_FETCH;
        end
      end
      S_REV0: begin
        // The top of the first chain is the rightmost point, which the second
        // chain supplies; drop it here.
        uctl.pop   = clockwise_order;
        lctl.pop   = !clockwise_order;
        state_next = S_REV;
      end
      S_REV: begin
        if (f_cnt != '0) begin
          uctl.pop  = clockwise_order;
          lctl.pop  = !clockwise_order;
          rctl.push = 1'b1;
        end else begin
          state_next = S_EMITR;
        end
      end
      S_EMITR: begin
        result_valid_next     = 1'b1;
        result_next.hull_x    = r_top.x;
        result_next.hull_y    = r_top.y;
        result_next.hull_last = cap_last;
        rctl.pop              = 1'b1;
        res_cnt_next          = res_cnt + 1'b1;
        if (cap_last) begin
          state_next = S_DONE;
        end else if (r_cnt == mch_pkg::CNT_W'(1)) begin
          state_next = S_EMITS;
        end
      end
      S_EMITS: begin
        result_valid_next     = 1'b1;
        result_next.hull_x    = s_top.x;
        result_next.hull_y    = s_top.y;
        result_next.hull_last = cap_last ||
                                (s_cnt == (closed ? mch_pkg::CNT_W'(1) : mch_pkg::CNT_W'(2)));
        uctl.pop              = !clockwise_order;
        lctl.pop              = clockwise_order;
        res_cnt_next          = res_cnt + 1'b1;
        if (result_next.hull_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        sctl.clear       = 1'b1;
        uctl.clear       = 1'b1;
        lctl.clear       = 1'b1;
        rctl.clear       = 1'b1;
        point_count_next = '0;
        dropped_next     = 1'b0;
        state_next       = S_LOAD;
      end
      default: begin
        state_next = S_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_LOAD;
      clockwise_order <= 1'b0;
      point_count     <= '0;
      dropped         <= 1'b0;
      skip            <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      point_count  <= point_count_next;
      dropped      <= dropped_next;
      skip         <= skip_next;
      result_valid <= result_valid_next;
      if (cfg_we) begin
        clockwise_order <= cfg_data;
      end
    end
  end

  // Payload and scan registers need no reset.
  always_ff @(posedge clk) begin
    closed    <= closed_next;
    remain    <= remain_next;
    drain_cnt <= drain_cnt_next;
    wait_cnt  <= wait_cnt_next;
    echo_idx  <= echo_idx_next;
    res_cnt   <= res_cnt_next;
    cur       <= cur_next;
    result    <= result_next;
    if (store) begin
      last_pt <= in_pt;
      if (point_count == '0) begin
        first_pt <= in_pt;
      end
    end
  end

  for (genvar e = 0; e < mch_pkg::ECHO_COUNT; e++) begin : g_echo
    always_ff @(posedge clk) begin
      if (store && (point_count == mch_pkg::CNT_W'(e))) begin
        echo[e] <= in_pt;
      end
    end
  end

  // A stack is never pushed and popped in the same cycle.
  a_stack_excl: assert property (@(posedge clk) disable iff (rst)
    !(uctl.push && uctl.pop) && !(lctl.push && lctl.pop))
    else $error("stack pushed and popped together");

  // The final vertex of a hull is followed by a quiet cycle.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.hull_last |=> !result_valid)
    else $error("transfer directly after final vertex");

  // The last point of a path always starts the hull computation.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    accept && item.last_point |=> busy)
    else $error("block idle after last point");

  // No result appears while points are still being loaded.
  a_quiet_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) && $past(state == S_LOAD) |-> !result_valid)
    else $error("transfer during load");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for monotone_chain_convex_hull
// Paths of points are sent with random gaps. A behavioural hull model in the
// bench predicts every emitted vertex, and the monitor compares each result
// transfer against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module testbench;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  mch_pkg::item_t   item = '0;
  logic             result_valid;
  mch_pkg::result_t result;
  logic             cfg_we = 1'b0;
  logic             cfg_data = 1'b0;

  monotone_chain_convex_hull uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Stimulus queue, prediction queue and the bench's own copy of the state.
  mch_pkg::item_t   pending_points[$];
  mch_pkg::result_t expected_vertices[$];
  mch_pkg::pt_t     path_store[mch_pkg::MAX_POINTS];
  int               path_count;
  bit               path_dropped;
  bit               clockwise;
  int               errors;
  int               sent_points;
  int               vertices_seen;
  int               paths_done;
  longint           cycles;

  // Sign of (q.y-p.y)*(r.x-p.x) - (q.x-p.x)*(r.y-p.y), computed exactly.
  function automatic int orient(mch_pkg::pt_t p, mch_pkg::pt_t q, mch_pkg::pt_t r);
    logic signed [127:0] px, py, qx, qy, rx, ry, a, b, d;
    px = p.x; py = p.y;
    qx = q.x; qy = q.y;
    rx = r.x; ry = r.y;
    a = (qy - py) * (rx - px);
    b = (qx - px) * (ry - py);
    d = a - b;
    if (d < 0) return -1;
    if (d == 0) return 0;
    return 1;
  endfunction

  function automatic bit pt_less(mch_pkg::pt_t a, mch_pkg::pt_t b);
    if (a.x != b.x) return a.x < b.x;
    return a.y < b.y;
  endfunction

  function automatic void emit_vertex(mch_pkg::pt_t p, bit ovf);
    mch_pkg::result_t r;
    r.hull_x = p.x; r.hull_y = p.y;
    r.hull_last = 1'b0; r.no_hull = 1'b0; r.overflow = ovf;
    expected_vertices = {expected_vertices, r};
  endfunction

  // Builds the expected vertices of the stored path; the store is emptied.
  task automatic predict_hull();
    mch_pkg::pt_t     pts[$];
    int               up[$];
    int               lo[$];
    int               n, first_idx, i, j;
    bit               closed;
    bit               ovf;
    mch_pkg::pt_t     t;
    mch_pkg::result_t r;
    n = path_count;
    ovf = path_dropped;
    closed = 1'b0;
    first_idx = expected_vertices.size();
    if (n < mch_pkg::ECHO_COUNT) begin
      r = '0;
      r.hull_last = 1'b1; r.no_hull = 1'b1; r.overflow = ovf;
      expected_vertices = {expected_vertices, r};
    end else if (n == mch_pkg::ECHO_COUNT) begin
      for (i = 0; i < n; i++) emit_vertex(path_store[i], ovf);
    end else begin
      if (path_store[0] == path_store[n-1]) begin
        closed = 1'b1;
        n--;
      end
      for (i = 0; i < n; i++) pts = {pts, path_store[i]};
      // Insertion sort keeps equal points in arrival order, as the block does.
      for (i = 1; i < n; i++) begin
        t = pts[i];
        j = i;
        while (j > 0 && pt_less(t, pts[j-1])) begin
          pts[j] = pts[j-1];
          j--;
        end
        pts[j] = t;
      end
      for (i = 0; i < n; i++) begin
        while (up.size() > 1 && orient(pts[up[$-1]], pts[up[$]], pts[i]) <= 0)
          up.delete(up.size() - 1);
        while (lo.size() > 1 && orient(pts[lo[$-1]], pts[lo[$]], pts[i]) >= 0)
          lo.delete(lo.size() - 1);
        up = {up, i};
        lo = {lo, i};
      end
      if (clockwise) begin
        for (i = 0; i + 1 < up.size(); i++) emit_vertex(pts[up[i]], ovf);
        for (i = lo.size() - 1; i >= 1; i--) emit_vertex(pts[lo[i]], ovf);
        if (closed) emit_vertex(pts[lo[0]], ovf);
      end else begin
        for (i = 0; i + 1 < lo.size(); i++) emit_vertex(pts[lo[i]], ovf);
        for (i = up.size() - 1; i >= 1; i--) emit_vertex(pts[up[i]], ovf);
        if (closed) emit_vertex(pts[up[0]], ovf);
      end
    end
    // Cap at the result limit, then mark the final vertex.
    while (expected_vertices.size() - first_idx > mch_pkg::MAX_RESULTS)
      expected_vertices.delete(expected_vertices.size() - 1);
    if (expected_vertices.size() > first_idx)
      expected_vertices[$].hull_last = 1'b1;
    path_count = 0;
    path_dropped = 1'b0;
  endtask

  // Model update for one accepted point transfer.
  task automatic accept_point(mch_pkg::item_t it);
    if (path_count < mch_pkg::MAX_POINTS) begin
      path_store[path_count].x = it.point_x;
      path_store[path_count].y = it.point_y;
      path_count++;
    end else begin
      path_dropped = 1'b1;
    end
    if (it.last_point) predict_hull();
  endtask

  // Driver: bursts of back-to-back transfers separated by random gaps.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        accept_point(item);
        sent_points++;
        void'(pending_points.pop_front());
      end
      if (start && busy) begin
        // Keep the offered transfer steady until it is taken.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_points.size() > 0) begin
        item <= pending_points[0];
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          if ($urandom_range(0, 3) != 0) gap_left <= $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe is one result transfer, checked against the oldest
  // prediction.
  always @(posedge clk) begin
    mch_pkg::result_t want;
    if (!rst && result_valid) begin
      vertices_seen++;
      if (expected_vertices.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, result);
        errors++;
      end else begin
        want = expected_vertices.pop_front();
        if (result.hull_x !== want.hull_x)
          $display("%0t: hull_x mismatch, expected %0d, actual %0d",
                   $time, want.hull_x, result.hull_x);
        if (result.hull_y !== want.hull_y)
          $display("%0t: hull_y mismatch, expected %0d, actual %0d",
                   $time, want.hull_y, result.hull_y);
        if (result.hull_last !== want.hull_last)
          $display("%0t: hull_last mismatch, expected %0b, actual %0b",
                   $time, want.hull_last, result.hull_last);
        if (result.no_hull !== want.no_hull)
          $display("%0t: no_hull mismatch, expected %0b, actual %0b",
                   $time, want.no_hull, result.no_hull);
        if (result.overflow !== want.overflow)
          $display("%0t: overflow mismatch, expected %0b, actual %0b",
                   $time, want.overflow, result.overflow);
        if (result !== want) begin
          errors++;
          if (want.hull_last) paths_done++;
        end else if (want.hull_last) begin
          paths_done++;
        end
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Random coordinate: mostly a small grid so that collinear and repeated
  // points are common, sometimes the extremes or a fully random value.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom();
      default: return $signed($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  task automatic queue_path(int n, bit close_it, bit extreme);
    mch_pkg::item_t it;
    mch_pkg::item_t first;
    int i;
    for (i = 0; i < n; i++) begin
      it.point_x = extreme ? $urandom() : rand_coord();
      it.point_y = extreme ? $urandom() : rand_coord();
      it.last_point = (i == n - 1);
      if (i == 0) first = it;
      if (close_it && i == n - 1 && n > 1) begin
        it.point_x = first.point_x;
        it.point_y = first.point_y;
      end
      pending_points = {pending_points, it};
    end
  endtask

  task automatic queue_fixed(logic signed [31:0] x, logic signed [31:0] y, bit lst);
    mch_pkg::item_t it;
    it.point_x = x; it.point_y = y; it.last_point = lst;
    pending_points = {pending_points, it};
  endtask

  // Waits until every queued point has been taken and every vertex has come,
  // then lets the block's tail drain before a configuration write.
  task automatic drain();
    while (pending_points.size() > 0 || start || expected_vertices.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_order(bit cw);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= cw;
    @(posedge clk);
    cfg_we <= 1'b0;
    clockwise = cw;
  endtask

  initial begin
    int sent_target;
    errors = 0; sent_points = 0; vertices_seen = 0; paths_done = 0;
    path_count = 0; path_dropped = 1'b0; clockwise = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, counter-clockwise after reset: single point, two points,
    // three-point echo, a closed square at the extremes, collinear points.
    queue_fixed(32'sd5, -32'sd5, 1'b1);
    queue_fixed(32'sd1, 32'sd2, 1'b0);
    queue_fixed(32'sd3, 32'sd4, 1'b1);
    queue_fixed(32'sd9, 32'sd0, 1'b0);
    queue_fixed(-32'sd9, 32'sd1, 1'b0);
    queue_fixed(32'sd0, 32'sd7, 1'b1);
    queue_fixed(32'sh80000000, 32'sh80000000, 1'b0);
    queue_fixed(32'sh7fffffff, 32'sh80000000, 1'b0);
    queue_fixed(32'sh7fffffff, 32'sh7fffffff, 1'b0);
    queue_fixed(32'sh80000000, 32'sh7fffffff, 1'b0);
    queue_fixed(32'sh80000000, 32'sh80000000, 1'b1);
    queue_fixed(32'sd0, 32'sd0, 1'b0);
    queue_fixed(32'sd1, 32'sd1, 1'b0);
    queue_fixed(32'sd2, 32'sd2, 1'b0);
    queue_fixed(32'sd3, 32'sd3, 1'b1);
    drain();

    // Clockwise: a full store followed by dropped points, last one dropped, then a closed path.
    write_order(1'b1);
    queue_path(mch_pkg::MAX_POINTS + 3, 1'b0, 1'b1);
    queue_path(6, 1'b1, 1'b0);
    drain();

    // Random part, with a random direction for each phase.
    sent_target = 280;
    while (sent_points < sent_target) begin
      write_order(1'($urandom_range(0, 1)));
      repeat ($urandom_range(2, 5)) begin
        case ($urandom_range(0, 9))
          0: queue_path($urandom_range(1, 3), 1'b0, 1'b0);
          1: queue_path($urandom_range(mch_pkg::MAX_POINTS - 1, mch_pkg::MAX_POINTS + 4),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          2: queue_path($urandom_range(4, 12), 1'b0, 1'b1);
          default: queue_path($urandom_range(4, 14), 1'($urandom_range(0, 1)), 1'b0);
        endcase
      end
      drain();
    end
    write_order(1'b0);
    queue_path(8, 1'b1, 1'b0);
    drain();

    $display("Run covered %0d point transfers and %0d paths, %0d vertices checked.",
             sent_points, paths_done, vertices_seen);
    $display("Both hull directions, no-hull, echo, closed and overflow paths included.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
